// ===== src/crc32z_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32z_pkg: shared definitions for the CRC zero-extension shift block
// Widths, reset polynomial and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package crc32z_pkg;

    localparam int CRC_W      = 32;
    localparam int CNT_W      = 32;
    // Count bits left after the byte count is split into words of four bytes
    localparam int WCNT_W     = CNT_W - 2;
    // Serial step counter: one product bit per cycle
    localparam int STEP_W     = $clog2(CRC_W);
    // Bit shifts for the sub-word part of the count: up to 24 fits in 5 bits
    localparam int SHIFT_W    = 5;

    localparam logic [CRC_W-1:0] RESET_POLY = 32'hEDB88320;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SHIFT  = 4'b0010,
        ST_MUL    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== src/crc32_zero_extend_shift.sv =====
// ----------------------------------------------------------------------------
// crc32_zero_extend_shift: advance a reflected CRC over a run of zero bytes
// Bit-serial shift and GF(2) square-and-multiply sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries s_crc_in and s_byte_count, one
//   request at a time; s_ready is high only while the sequencer is idle.
//   Result channel m_valid/m_ready carries m_crc_out from an output register,
//   so the sequencer returns to idle and takes the next request while a
//   finished result still waits for the receiver.
//   Configuration channel cfg_valid/cfg_ready/cfg_data writes the reflected
//   polynomial; cfg_ready is always high. Write it only while idle.
// Sequence, with n = byte_count:
//   load the request, one single-bit shift per zero bit of the n mod 4
//   leftover bytes, a step to pick the next phase, then for each significant
//   bit of n/4 a pass over every multiplier bit (two bit-serial carry-less
//   multipliers run side by side, one product bit per cycle), then the move
//   into the output register. n = 0 skips the shifts and the products.
// Reset: aresetn (synchronous, active low) clears the sequencer and the
//   output valid, and restores the polynomial to 0xEDB88320.
// Stall: a held result blocks the sequencer only once the next result is
//   ready to move into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_zero_extend_shift (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [crc32z_pkg::CRC_W-1:0]  s_crc_in,
    input  wire logic [crc32z_pkg::CNT_W-1:0]  s_byte_count,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [crc32z_pkg::CRC_W-1:0]  m_crc_out,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [crc32z_pkg::CRC_W-1:0]  cfg_data
);
    import crc32z_pkg::*;

    state_t              state_reg,   state_next;
    logic [CRC_W-1:0]    poly_reg;
    logic [CRC_W-1:0]    crc_reg,     crc_next;
    logic [CRC_W-1:0]    pw_reg,      pw_next;
    logic [WCNT_W-1:0]   wcnt_reg,    wcnt_next;
    logic [SHIFT_W-1:0]  shift_reg,   shift_next;
    logic [STEP_W-1:0]   step_reg,    step_next;
    logic [CRC_W-1:0]    acc_c_reg,   acc_c_next;
    logic [CRC_W-1:0]    acc_p_reg,   acc_p_next;
    logic [CRC_W-1:0]    sh_c_reg,    sh_c_next;
    logic [CRC_W-1:0]    sh_p_reg,    sh_p_next;
    logic                m_valid_reg, m_valid_next;
    logic [CRC_W-1:0]    out_reg,     out_next;
    logic                out_free;
    logic                last_step;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_crc_out = out_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (step_reg == STEP_W'(CRC_W - 1));

    // Hold the polynomial; take writes whenever they arrive
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= RESET_POLY;
        end else if (cfg_valid) begin
            poly_reg <= cfg_data;
        end
    end

    // Sequence shifts and serial products
    always_comb begin
        state_next   = state_reg;
        crc_next     = crc_reg;
        pw_next      = pw_reg;
        wcnt_next    = wcnt_reg;
        shift_next   = shift_reg;
        step_next    = step_reg;
        acc_c_next   = acc_c_reg;
        acc_p_next   = acc_p_reg;
        sh_c_next    = sh_c_reg;
        sh_p_next    = sh_p_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        // drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    crc_next   = s_crc_in;
                    pw_next    = poly_reg;
                    wcnt_next  = s_byte_count[CNT_W-1:2];
                    shift_next = {s_byte_count[1:0], 3'b000};
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (shift_reg != '0) begin
                    // one reflected shift step per cycle
                    crc_next   = (crc_reg >> 1) ^ (crc_reg[0] ? poly_reg : '0);
                    shift_next = shift_reg - 1'b1;
                end else if (wcnt_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    acc_c_next = '0;
                    acc_p_next = '0;
                    sh_c_next  = crc_reg;
                    sh_p_next  = pw_reg;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // advance both products by one multiplier bit
                acc_c_next = (acc_c_reg >> 1) ^ (acc_c_reg[0] ? poly_reg : '0)
                             ^ (sh_c_reg[0] ? pw_reg : '0);
                acc_p_next = (acc_p_reg >> 1) ^ (acc_p_reg[0] ? poly_reg : '0)
                             ^ (sh_p_reg[0] ? pw_reg : '0);
                sh_c_next  = sh_c_reg >> 1;
                sh_p_next  = sh_p_reg >> 1;
                step_next  = step_reg + 1'b1;
                if (last_step) begin
                    if (wcnt_reg[0]) begin
                        crc_next = acc_c_next;
                    end
                    pw_next   = acc_p_next;
                    wcnt_next = wcnt_reg >> 1;
                    if (wcnt_reg[WCNT_W-1:1] == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        acc_c_next = '0;
                        acc_p_next = '0;
                        sh_c_next  = crc_next;
                        sh_p_next  = pw_next;
                    end
                end
            end
            ST_FINISH: begin
                // move the result out once the output register is free
                if (out_free) begin
                    out_next     = crc_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        crc_reg   <= crc_next;
        pw_reg    <= pw_next;
        wcnt_reg  <= wcnt_next;
        shift_reg <= shift_next;
        step_reg  <= step_next;
        acc_c_reg <= acc_c_next;
        acc_p_reg <= acc_p_next;
        sh_c_reg  <= sh_c_next;
        sh_p_reg  <= sh_p_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

// ===== sim/crc_shift_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_shift_checker: result predictor and scoreboard for the CRC shift block
// Watches the configuration, request and result channels. Each accepted
// request is advanced over its zero bytes with the current polynomial and
// queued; each accepted result is compared with the oldest queued value.
// ----------------------------------------------------------------------------

module crc_shift_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [crc32z_pkg::CRC_W-1:0]  s_crc_in,
    input  logic [crc32z_pkg::CNT_W-1:0]  s_byte_count,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [crc32z_pkg::CRC_W-1:0]  m_crc_out,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [crc32z_pkg::CRC_W-1:0]  cfg_data,
    output int                            mismatch_count,
    output int                            pending
);

    import crc32z_pkg::*;

    typedef struct {
        logic [CRC_W-1:0] crc_in;
        logic [CNT_W-1:0] byte_count;
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] crc_out;
    } shift_rec_t;

    logic [CRC_W-1:0] cur_poly;
    shift_rec_t       pending_crcs[$];

    // Carry-less product of a and b, reduced by poly, reflected bit order
    function automatic logic [CRC_W-1:0] gf2_mulmod(input logic [CRC_W-1:0] a,
                                                    input logic [CRC_W-1:0] b,
                                                    input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] acc;
        logic [CRC_W-1:0] ra;
        int k;
        ra  = a;
        acc = ra[0] ? b : '0;
        for (k = 0; k < CRC_W - 1; k++) begin
            acc = (acc >> 1) ^ (acc[0] ? poly : '0);
            ra  = ra >> 1;
            acc = acc ^ (ra[0] ? b : '0);
        end
        return acc;
    endfunction

    // CRC after cnt zero bytes: bit steps for cnt mod 4, then square-and-multiply
    // over the word count, starting from x^32 mod P (the polynomial itself)
    function automatic logic [CRC_W-1:0] crc_after_zeros(input logic [CRC_W-1:0] crc,
                                                         input logic [CNT_W-1:0] cnt,
                                                         input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0]  r;
        logic [CRC_W-1:0]  pw;
        logic [WCNT_W-1:0] words;
        int k;
        r  = crc;
        pw = poly;
        for (k = 0; k < 8 * int'(cnt[1:0]); k++)
            r = (r >> 1) ^ (r[0] ? poly : '0);
        words = cnt[CNT_W-1:2];
        while (words != '0) begin
            if (words[0])
                r = gf2_mulmod(r, pw, poly);
            words = words >> 1;
            if (words != '0)
                pw = gf2_mulmod(pw, pw, poly);
        end
        return r;
    endfunction

    initial begin
        mismatch_count = 0;
        pending        = 0;
        cur_poly       = RESET_POLY;
    end

    // Track the polynomial, queue predictions, compare results
    always @(posedge aclk) begin
        shift_rec_t rec;
        if (!aresetn) begin
            cur_poly = RESET_POLY;
            pending_crcs.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                cur_poly = cfg_data;

            if (s_valid && s_ready) begin
                rec.crc_in     = s_crc_in;
                rec.byte_count = s_byte_count;
                rec.poly       = cur_poly;
                rec.crc_out    = crc_after_zeros(s_crc_in, s_byte_count, cur_poly);
                pending_crcs.push_back(rec);
            end

            if (m_valid && m_ready) begin
                if (pending_crcs.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("[%0t] unexpected result crc_out=%h with no request pending",
                                 $realtime, m_crc_out);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    rec = pending_crcs.pop_front();
                    if (m_crc_out !== rec.crc_out) begin
                        if (mismatch_count < 10) begin
                            $display("[%0t] crc_out mismatch: crc_in=%h byte_count=%h poly=%h",
                                     $realtime, rec.crc_in, rec.byte_count, rec.poly);
                            $display("    expected %h got %h", rec.crc_out, m_crc_out);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
        pending <= pending_crcs.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the CRC zero-extension shift block
// Drives requests through several polynomials, from a short directed set to
// random counts of all sizes, with random idling on both channels and one
// long receiver hold. The checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_top;

    import crc32z_pkg::*;

    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 67;
    localparam int HOLD_CYCLES    = 300;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [CRC_W-1:0] s_crc_in = '0;
    logic [CNT_W-1:0] s_byte_count = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [CRC_W-1:0] m_crc_out;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CRC_W-1:0] cfg_data = '0;

    int mismatch_count;
    int pending;

    // Idling controls shared by the sender and the receiver
    bit quiet = 1'b0;
    bit rx_hold_req = 1'b0;

    always #1 aclk = ~aclk;

    crc32_zero_extend_shift dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_crc_in     (s_crc_in),
        .s_byte_count (s_byte_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_crc_out    (m_crc_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    crc_shift_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_crc_in       (s_crc_in),
        .s_byte_count   (s_byte_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_crc_out      (m_crc_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // Offer one request after a random gap, or none while quiet; return at the edge it is taken
    task automatic offer_request(input logic [CRC_W-1:0] crc, input logic [CNT_W-1:0] cnt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_crc_in     <= crc;
        s_byte_count <= cnt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_polynomial(input logic [CRC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CRC_W-1:0] phase_poly(input int p);
        case (p)
            0: return 32'hEDB88320;
            1: return 32'h82F63B78;
            2: return 32'h00000000;
            3: return 32'hFFFFFFFF;
            4: return 32'h00000001;
            5: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short counts, some full range, some edge values
    function automatic logic [CNT_W-1:0] rand_count();
        logic [CNT_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h0;
                    1: v = 32'h1;
                    2: v = 32'h2;
                    3: v = 32'h3;
                    4: v = 32'hFFFFFFFF;
                    default: v = 32'hFFFFFFFC;
                endcase
            end
            2, 3, 4, 5: v = $urandom_range(0, 63);
            6, 7, 8: v = $urandom_range(0, 4095);
            default: v = (32'h1 << $urandom_range(0, 31)) | $urandom_range(0, 3);
        endcase
        return v;
    endfunction

    function automatic logic [CRC_W-1:0] rand_crc();
        logic [CRC_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 32'h1 << $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Receiver: random stall per result, plus one long hold on request
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            gap = quiet ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Stimulus and verdict
    initial begin
        int p;
        int i;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (p = 0; p < PHASES; p++) begin
            drain_results();
            write_polynomial(phase_poly(p));

            if (p == 0) begin
                // Zero count, counts below four, word counts, extremes
                offer_request(32'h00000000, 32'h00000000);
                offer_request(32'hFFFFFFFF, 32'h00000000);
                offer_request(32'h12345678, 32'h00000001);
                offer_request(32'h12345678, 32'h00000002);
                offer_request(32'h12345678, 32'h00000003);
                offer_request(32'hFFFFFFFF, 32'h00000003);
                offer_request(32'h00000001, 32'h00000004);
                offer_request(32'h80000000, 32'h00000005);
                offer_request(32'hDEADBEEF, 32'h00000007);
                offer_request(32'hCBF43926, 32'h00000008);
                offer_request(32'h00000000, 32'hFFFFFFFF);
                offer_request(32'hFFFFFFFF, 32'hFFFFFFFF);
                offer_request(32'hFFFFFFFF, 32'hFFFFFFFC);
                offer_request(32'hA5A5A5A5, 32'h80000000);
                offer_request(32'h5A5A5A5A, 32'h7FFFFFFF);
                offer_request(32'h00000001, 32'h00001000);
            end

            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                quiet = (i >= 20 && i < 36);
                if (p == 1 && i == 8)
                    rx_hold_req = 1'b1;
                offer_request(rand_crc(), rand_count());
            end
            quiet = 1'b0;
        end

        drain_results();
        repeat (40) @(posedge aclk);

        if (mismatch_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
